// ----- rtl/slt_pkg.sv -----
// Shared types and constants for the sorted list table.
// Used by slt_cell and sorted_list_table; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_ABSENT = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                      smp;    // latch compare flags against probe
    logic                      ins;    // open a slot and write key
    logic                      rem;    // close the gap at the first match
    logic                      clr;    // drop all entries
    logic signed [VALUE_W-1:0] probe;  // value of the request being accepted
    logic signed [VALUE_W-1:0] key;    // value of the request being executed
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_table.sv -----
// Sorted list table: a row of compare cells holding signed values in order.
// At acceptance every cell compares its entry with the request value; then,
// once no waiting result is stalled, the row shifts and the result is
// registered. A new request is taken only after that, never while one is in
// progress. Reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_action,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_found,
  output logic [1:0]                     out_status,
  output logic [COUNT_OUT_W-1:0]         out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                    st_r, st_nxt;
  action_t                   act_r;
  logic signed [VALUE_W-1:0] key_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      out_valid_r, out_found_r;
  logic [1:0]                out_status_r;
  logic [COUNT_OUT_W-1:0]    out_count_r;

  logic accept, upd, full, found;
  logic found_res;
  status_t status_res;
  logic [CW+COUNT_OUT_W-1:0] count_ext;
  cell_ctl_t ctl;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]       vld_w, aft_w, eq_w;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_EXEC;
      ST_EXEC: if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    upd      = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_EXEC: upd = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign full  = (count_r == CAP_C);
  assign found = |eq_w;

  always_comb begin
    ctl       = '0;
    ctl.smp   = accept;
    ctl.probe = in_value;
    ctl.key   = key_r;
    ctl.ins   = upd && (act_r == ACT_INSERT) && !full;
    ctl.rem   = upd && (act_r == ACT_REMOVE) && found;
    ctl.clr   = upd && (act_r == ACT_CLEAR);
  end

  always_comb begin
    count_nxt  = count_r;
    found_res  = 1'b0;
    status_res = STS_DONE;
    unique case (act_r)
      ACT_INSERT: begin
        if (full) status_res = STS_FULL;
        else count_nxt = count_r + CW'(1);
      end
      ACT_REMOVE: begin
        if (found) begin
          found_res = 1'b1;
          count_nxt = count_r - CW'(1);
        end else begin
          status_res = STS_ABSENT;
        end
      end
      ACT_SEARCH: begin
        if (found) found_res = 1'b1;
        else status_res = STS_ABSENT;
      end
      ACT_CLEAR: count_nxt = '0;
      default: count_nxt = count_r;
    endcase
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= upd || (out_valid_r && out_stall);
      if (upd) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action_t'(in_action);
      key_r <= in_value;
    end
    if (upd) begin
      out_found_r  <= found_res;
      out_status_r <= status_res;
      out_count_r  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] l_entry, r_entry;
    logic                      l_vld, l_aft, r_vld;
    if (i == 0) begin : g_first
      assign l_entry = key_r;
      assign l_vld   = 1'b1;
      assign l_aft   = 1'b0;
    end else begin : g_mid
      assign l_entry = entry_w[i-1];
      assign l_vld   = vld_w[i-1];
      assign l_aft   = aft_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = '0;
      assign r_vld   = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
      assign r_vld   = vld_w[i+1];
    end

    slt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (l_entry),
      .left_vld    (l_vld),
      .left_aft    (l_aft),
      .right_entry (r_entry),
      .right_vld   (r_vld),
      .entry       (entry_w[i]),
      .vld         (vld_w[i]),
      .aft         (aft_w[i]),
      .eq          (eq_w[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

// ----- rtl/slt_cell.sv -----
// One cell of the sorted row: holds one entry, its valid bit and compare flags.
// Depends on slt_pkg for the control struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module slt_cell
  import slt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cell_ctl_t                 ctl,
  input  wire logic signed [VALUE_W-1:0] left_entry,
  input  wire logic                      left_vld,
  input  wire logic                      left_aft,
  input  wire logic signed [VALUE_W-1:0] right_entry,
  input  wire logic                      right_vld,
  output logic signed [VALUE_W-1:0]      entry,
  output logic                           vld,
  output logic                           aft,
  output logic                           eq
);

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic                      vld_r, vld_nxt;
  // aft: the cell lies past the insert point (empty or greater than the probe).
  logic                      aft_r, ge_r, eq_r;

  always_comb begin
    entry_nxt = entry_r;
    vld_nxt   = vld_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.ins && aft_r) begin
      entry_nxt = left_aft ? left_entry : ctl.key;
      vld_nxt   = vld_r | left_vld;
    end else if (ctl.rem && ge_r) begin
      entry_nxt = right_entry;
      vld_nxt   = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.smp) begin
      aft_r <= !vld_r || (entry_r > ctl.probe);
      ge_r  <= vld_r && (entry_r >= ctl.probe);
      eq_r  <= vld_r && (entry_r == ctl.probe);
    end
  end

  assign entry = entry_r;
  assign vld   = vld_r;
  assign aft   = aft_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire
